/* rtl/core/rde_pkg.sv */
// Shared constants, types and a function for the radix digit emitter.
package rde_pkg;

   localparam int VALUE_BITS     = 31;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;
   localparam int BIT_CNT_BITS   = $clog2(VALUE_BITS);
   localparam int DEPTH_CNT_BITS = $clog2(VALUE_BITS + 1);

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN      = DIGIT_BITS'(10);
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO      = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA_OFS = CHAR_BITS'(55);

   typedef struct packed {
      logic                  digit_valid;
      logic [DIGIT_BITS-1:0] digit;
      logic                  final_digit;
   } div_status_type;

   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [DIGIT_BITS-1:0] digit;
   } stack_ctl_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ext;
      ext = CHAR_BITS'(d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + ext;
      end
      return CHAR_ALPHA_OFS + ext;
   endfunction

endpackage

/* rtl/core/rde_channels.sv */
// Valid/ready channel interfaces for requests and digit results.
interface rde_req_if;
   logic                             valid;
   logic                             ready;
   logic [rde_pkg::VALUE_BITS-1:0]   value;
   logic [rde_pkg::RADIX_BITS-1:0]   radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rde_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rde_pkg::CHAR_BITS-1:0]    digit_char;
   logic                             last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* rtl/core/rde_divider.sv */
// Bit-serial restoring divider that peels off one digit per pass.
module rde_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rde_pkg::VALUE_BITS-1:0]   value,
   input  logic [rde_pkg::RADIX_BITS-1:0]   radix,
   output rde_pkg::div_status_type          status
);

   localparam int VB = rde_pkg::VALUE_BITS;
   localparam logic [rde_pkg::BIT_CNT_BITS-1:0] LAST_BIT = rde_pkg::BIT_CNT_BITS'(VB - 1);

   logic [VB-1:0]                       quot_ff, quot_in;
   logic [rde_pkg::DIGIT_BITS-1:0]      rem_ff, rem_in;
   logic [rde_pkg::RADIX_BITS-1:0]      radix_ff, radix_in;
   logic [rde_pkg::BIT_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                                nz_ff, nz_in;
   logic                                busy_ff, busy_in;

   logic [rde_pkg::RADIX_BITS-1:0]      trial;
   logic [rde_pkg::RADIX_BITS-1:0]      diff;
   logic                                qbit;
   logic [rde_pkg::DIGIT_BITS-1:0]      rem_step;
   logic                                pass_end;
   logic                                nz_step;
   logic [rde_pkg::RADIX_BITS-1:0]      radix_sat;

   always_comb begin
      trial    = {rem_ff, quot_ff[VB-1]};
      diff     = trial - radix_ff;
      qbit     = (trial >= radix_ff);
      rem_step = qbit ? diff[rde_pkg::DIGIT_BITS-1:0] : trial[rde_pkg::DIGIT_BITS-1:0];
      pass_end = (cnt_ff == LAST_BIT);
      nz_step  = nz_ff | qbit;

      if (radix < rde_pkg::RADIX_MIN) begin
         radix_sat = rde_pkg::RADIX_MIN;
      end else if (radix > rde_pkg::RADIX_MAX) begin
         radix_sat = rde_pkg::RADIX_MAX;
      end else begin
         radix_sat = radix;
      end

      quot_in  = quot_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      cnt_in   = cnt_ff;
      nz_in    = nz_ff;
      busy_in  = busy_ff;

      if (start) begin
         quot_in  = value;
         rem_in   = '0;
         radix_in = radix_sat;
         cnt_in   = '0;
         nz_in    = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VB-2:0], qbit};
         if (pass_end) begin
            rem_in  = '0;
            cnt_in  = '0;
            nz_in   = 1'b0;
            busy_in = nz_step;
         end else begin
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            nz_in  = nz_step;
         end
      end

      status.digit_valid = busy_ff & pass_end;
      status.digit       = rem_step;
      status.final_digit = ~nz_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      nz_ff    <= nz_in;
   end

endmodule

/* rtl/core/rde_digit_stack.sv */
// Shift-register digit stack: digits go in least significant first, come out reversed.
module rde_digit_stack (
   input  logic                             clock,
   input  logic                             reset,
   input  rde_pkg::stack_ctl_type           ctl,
   output logic [rde_pkg::DIGIT_BITS-1:0]   top_digit,
   output logic                             top_last
);

   localparam int VB = rde_pkg::VALUE_BITS;

   logic [rde_pkg::DIGIT_BITS-1:0]      ent_ff [VB];
   logic [rde_pkg::DIGIT_BITS-1:0]      ent_in [VB];
   logic [rde_pkg::DEPTH_CNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      for (int i = 0; i < VB; i++) begin
         ent_in[i] = ent_ff[i];
      end
      count_in = count_ff;
      if (ctl.push) begin
         ent_in[0] = ctl.digit;
         for (int i = 1; i < VB; i++) begin
            ent_in[i] = ent_ff[i-1];
         end
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         for (int i = 0; i < VB - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   assign top_digit = ent_ff[0];
   assign top_last  = (count_ff == rde_pkg::DEPTH_CNT_BITS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < VB; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

endmodule

/* rtl/core/radix_digit_emitter_top.sv */
// Radix digit emitter: converts an integer to base-2..16 ASCII digits, most significant first.
// Each digit takes one divider pass over all VALUE_BITS bits, one quotient bit per cycle.
// A request of N digits is busy for N divider passes, then for the emission of its N digits.
// Worst case is base 2, with 31 digits.
// A new request is taken only after the last digit is popped into the output register.
// Synchronous active-high reset clears the controller, divider and stack count.
module radix_digit_emitter_top (
   input  logic        clock,
   input  logic        reset,
   rde_req_if.sink     req_chan,
   rde_rsp_if.source   rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   rde_pkg::div_status_type          div_status;
   rde_pkg::stack_ctl_type           stack_ctl;
   logic [rde_pkg::DIGIT_BITS-1:0]   top_digit;
   logic                             top_last;
   logic                             start;

   logic                             out_valid_ff, out_valid_in;
   logic [rde_pkg::CHAR_BITS-1:0]    out_char_ff, out_char_in;
   logic                             out_last_ff, out_last_in;

   rde_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (req_chan.value),
      .radix  (req_chan.radix),
      .status (div_status)
   );

   rde_digit_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stack_ctl),
      .top_digit (top_digit),
      .top_last  (top_last)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign start          = req_chan.valid & req_chan.ready;

   always_comb begin
      state_in        = state_ff;
      stack_ctl.push  = 1'b0;
      stack_ctl.pop   = 1'b0;
      stack_ctl.digit = div_status.digit;
      out_valid_in    = out_valid_ff & ~rsp_chan.ready;
      out_char_in     = out_char_ff;
      out_last_in     = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.digit_valid) begin
               stack_ctl.push = 1'b1;
               if (div_status.final_digit) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               stack_ctl.pop = 1'b1;
               out_valid_in  = 1'b1;
               out_char_in   = rde_pkg::digit_to_char(top_digit);
               out_last_in   = top_last;
               if (top_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.digit_char = out_char_ff;
   assign rsp_chan.last_digit = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

/* rtl/core/rde_checker.sv */
// Port-level checker for the radix digit emitter, bound to the top level.
module rde_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rde_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   input logic                           rsp_last_digit
);

   // requests accepted whose last digit has not been taken yet
   logic [1:0] open_ff, open_in;

   always_comb begin
      open_in = open_ff;
      if (req_valid && req_ready) begin
         open_in = open_in + 2'd1;
      end
      if (rsp_valid && rsp_ready && rsp_last_digit) begin
         open_in = open_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last_digit))
      else $error("result changed while stalled");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
         (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd70))
      else $error("digit character out of range");

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("result without an open request");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_digit_char (rsp_chan.digit_char),
   .rsp_last_digit (rsp_chan.last_digit)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for radix_digit_emitter_top: random and directed conversions.
module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int TAIL_CYCLES    = 64;

   localparam logic [rde_pkg::CHAR_BITS-1:0] ASCII_ZERO    = 7'd48;
   localparam logic [rde_pkg::CHAR_BITS-1:0] ASCII_UPPER_A = 7'd65;

   typedef struct packed {
      logic [rde_pkg::VALUE_BITS-1:0] value;
      logic [rde_pkg::RADIX_BITS-1:0] radix;
   } conv_req_type;

   typedef struct packed {
      logic [rde_pkg::CHAR_BITS-1:0] digit_char;
      logic                          last_digit;
   } digit_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rde_req_if req_chan ();
   rde_rsp_if rsp_chan ();

   radix_digit_emitter_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   conv_req_type  conv_queue[$];
   digit_rsp_type digits_due[$];
   int            reqs_queued    = 0;
   int            reqs_accepted  = 0;
   int            digits_checked = 0;
   int            clamped_reqs   = 0;
   int            errors         = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            idle_cycles    = 0;
   int            hold_cnt       = 0;
   logic          hold_req       = 1'b0;
   logic          hold_taken     = 1'b0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.radix = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic logic [rde_pkg::CHAR_BITS-1:0] ascii_of(input logic [3:0] d);
      if (d < 4'd10) begin
         return ASCII_ZERO + rde_pkg::CHAR_BITS'(d);
      end
      return ASCII_UPPER_A + rde_pkg::CHAR_BITS'(d - 4'd10);
   endfunction

   // Expand one request into its digit string, most significant first.
   function automatic void queue_digits(input logic [rde_pkg::VALUE_BITS-1:0] val,
                                        input logic [rde_pkg::RADIX_BITS-1:0] rad);
      int unsigned                    base;
      logic [rde_pkg::VALUE_BITS-1:0] rest;
      logic [3:0]                     digs[$];
      digit_rsp_type                  item;
      base = rad;
      if (base < 2) begin
         base = 2;
      end
      if (base > 16) begin
         base = 16;
      end
      rest = val;
      do begin
         digs.push_front(4'(rest % base));
         rest = rde_pkg::VALUE_BITS'(rest / base);
      end while (rest != 0);
      for (int k = 0; k < digs.size(); k++) begin
         item.digit_char = ascii_of(digs[k]);
         item.last_digit = (k == digs.size() - 1);
         digits_due.push_back(item);
      end
   endfunction

   task automatic add_request(input logic [rde_pkg::VALUE_BITS-1:0] val,
                              input logic [rde_pkg::RADIX_BITS-1:0] rad);
      conv_req_type r;
      r.value = val;
      r.radix = rad;
      conv_queue.push_back(r);
      reqs_queued++;
      if (rad < rde_pkg::RADIX_MIN || rad > rde_pkg::RADIX_MAX) begin
         clamped_reqs++;
      end
   endtask

   // Random value widths so digit counts vary; radix mostly legal.
   task automatic add_random_requests(input int n, input int min_width);
      int                             width;
      logic [31:0]                    mask;
      logic [rde_pkg::RADIX_BITS-1:0] rad;
      for (int i = 0; i < n; i++) begin
         width = $urandom_range(31, min_width);
         mask  = (32'h1 << width) - 32'h1;
         if ($urandom_range(9) == 0) begin
            rad = rde_pkg::RADIX_BITS'($urandom_range(31));
         end else begin
            rad = rde_pkg::RADIX_BITS'($urandom_range(16, 2));
         end
         add_request(rde_pkg::VALUE_BITS'($urandom & mask), rad);
      end
   endtask

   task automatic drain();
      while (conv_queue.size() != 0 || reqs_accepted != reqs_queued
             || digits_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // request driver
   always @(posedge clock) begin
      conv_req_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            queue_digits(req_chan.value, req_chan.radix);
            reqs_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (conv_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               r = conv_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.value <= r.value;
               req_chan.radix <= r.radix;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // digit monitor
   always @(posedge clock) begin
      digit_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (digits_due.size() == 0) begin
               $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                        $time, rsp_chan.digit_char, rsp_chan.last_digit);
               errors++;
            end else begin
               want = digits_due.pop_front();
               digits_checked++;
               if (rsp_chan.digit_char !== want.digit_char) begin
                  $display("%0t: digit_char mismatch: expected %0d, got %0d",
                           $time, want.digit_char, rsp_chan.digit_char);
                  errors++;
               end
               if (rsp_chan.last_digit !== want.last_digit) begin
                  $display("%0t: last_digit mismatch: expected %0b, got %0b",
                           $time, want.last_digit, rsp_chan.last_digit);
                  errors++;
               end
            end
         end
         rsp_chan.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt   <= 0;
         hold_taken <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_cnt   <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      add_request(31'd0, 5'd10);
      add_request(31'h7FFF_FFFF, 5'd2);
      add_request(31'h7FFF_FFFF, 5'd16);
      add_request(31'h7FFF_FFFF, 5'd10);
      add_request(31'd1, 5'd2);
      add_request(31'd10, 5'd16);
      add_request(31'd15, 5'd16);
      add_request(31'd12345, 5'd0);
      add_request(31'd12345, 5'd1);
      add_request(31'd12345, 5'd17);
      add_request(31'd12345, 5'd31);
      for (int rad = 3; rad <= 15; rad++) begin
         add_request(rde_pkg::VALUE_BITS'(rad * rad - 1), rde_pkg::RADIX_BITS'(rad));
      end
      add_random_requests(100, 1);
      drain();

      set_idling(60, 0);
      add_random_requests(100, 1);
      drain();

      set_idling(0, 60);
      add_random_requests(100, 1);
      drain();

      set_idling(18, 18);
      add_random_requests(100, 1);
      drain();

      // hold results off while long conversions keep arriving
      set_idling(0, 0);
      hold_req <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         add_request(rde_pkg::VALUE_BITS'($urandom) | 31'h4000_0000, 5'd2);
      end
      add_random_requests(70, 1);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d conversions (%0d with out-of-range radix), checked %0d digits,",
               reqs_accepted, clamped_reqs, digits_checked);
      $display("across idle/stall phases and a %0d-cycle result hold-off.", HOLD_CYCLES);
      if (errors == 0 && digits_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
